@@ rtl/core/hbid_pkg.sv @@
package hbid_pkg;

  localparam int unsigned LeafWords = 1024;
  localparam int unsigned WordBits  = 64;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_BAD_REL  = 2'd2
  } status_code_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_TOP,
    S_RD,
    S_EVAL,
    S_FRD,
    S_FACC,
    S_RCHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic init_t;
    logic next_t;
    logic set_w;
    logic rd_word;
    logic next_w;
    logic alloc_wr;
    logic frd;
    logic facc;
    logic rel_rd;
    logic rel_wr;
    logic fail_alloc;
    logic fail_rel;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_rel;
    logic hint_oob;
    logic t_oob;
    logic top_full;
    logic w_end;
    logic avail_nz;
    logic fk_last;
    logic rbit;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/core/hbid_ctrl.sv @@
module hbid_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  hbid_pkg::stat_t st,
  output hbid_pkg::cmd_t  cmd,
  output logic           idle
);
  import hbid_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    idle = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        idle = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (st.is_rel) begin
          if (st.hint_oob) begin
            cmd.fail_rel = 1'b1;
            state_next = S_DONE;
          end else begin
            cmd.rel_rd = 1'b1;
            state_next = S_RCHK;
          end
        end else if (st.hint_oob) begin
          cmd.fail_alloc = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.init_t = 1'b1;
          state_next = S_TOP;
        end
      end
      S_TOP: begin
        if (st.t_oob) begin
          cmd.fail_alloc = 1'b1;
          state_next = S_DONE;
        end else if (st.top_full) begin
          cmd.next_t = 1'b1;
        end else begin
          cmd.set_w = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (st.w_end) begin
          cmd.next_t = 1'b1;
          state_next = S_TOP;
        end else begin
          cmd.rd_word = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (st.avail_nz) begin
          cmd.alloc_wr = 1'b1;
          state_next = S_FRD;
        end else begin
          cmd.next_w = 1'b1;
          state_next = S_RD;
        end
      end
      S_FRD: begin
        cmd.frd = 1'b1;
        state_next = S_FACC;
      end
      S_FACC: begin
        cmd.facc = 1'b1;
        state_next = st.fk_last ? S_DONE : S_FRD;
      end
      S_RCHK: begin
        if (st.rbit) begin
          cmd.rel_wr = 1'b1;
        end else begin
          cmd.fail_rel = 1'b1;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/hbid_dp.sv @@
module hbid_dp #(
  parameter int unsigned LEVELS = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  hbid_pkg::cmd_t  cmd,
  output hbid_pkg::stat_t st,
  input  logic            mode,
  input  logic [15:0]     row_id,
  input  logic            cfg_fire,
  input  logic [16:0]     capacity,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      status,
  output logic [15:0]     result_id
);
  import hbid_pkg::*;

  localparam logic [16:0] IdLim = (LEVELS == 1) ? 17'd256 : 17'd65536;

  logic [WordBits-1:0] mem [LeafWords];
  logic [WordBits-1:0] rdata;
  logic [255:0]        top;
  logic [16:0]         cap;
  logic [16:0]         cap_eff;
  logic [9:0]          clr;
  logic                mode_r;
  logic [15:0]         rid;
  logic [8:0]          t;
  logic [10:0]         w;
  logic [15:0]         lo;
  logic [1:0]          fk;
  logic [WordBits-1:0] acc;
  logic [1:0]          res_st;
  logic [15:0]         res_id;

  logic [16:0]         t_base, t_sum, hi, w_base, w_top, hsh;
  logic [10:0]         w_inc;
  logic [WordBits-1:0] lomask, himask, avail, wdata;
  logic [5:0]          b;
  logic [9:0]          raddr, waddr;
  logic                we, re;

  assign cap_eff = (cap > IdLim) ? IdLim : cap;
  assign t_base  = {t, 8'h00};
  assign t_sum   = t_base + 17'd256;
  assign hi      = (t_sum < cap_eff) ? t_sum : cap_eff;
  assign w_base  = {w, 6'b0};
  assign w_inc   = w + 11'd1;
  assign w_top   = {w_inc, 6'b0};
  assign hsh     = hi - w_base;
  assign lomask  = (w == {1'b0, lo[15:6]}) ? ({WordBits{1'b1}} << lo[5:0]) : {WordBits{1'b1}};
  assign himask  = (w_top > hi) ? ((64'd1 << hsh[5:0]) - 64'd1) : {WordBits{1'b1}};
  assign avail   = ~rdata & lomask & himask;

  always_comb begin
    b = 6'd0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (avail[i]) begin
        b = 6'(i);
      end
    end
  end

  assign st.clr_last = (clr == 10'(LeafWords - 1));
  assign st.is_rel   = mode_r;
  assign st.hint_oob = {1'b0, rid} >= cap_eff;
  assign st.t_oob    = t_base >= cap_eff;
  assign st.top_full = top[t[7:0]];
  assign st.w_end    = w_base >= hi;
  assign st.avail_nz = |avail;
  assign st.fk_last  = (fk == 2'd3);
  assign st.rbit     = rdata[rid[5:0]];
  assign st.out_free = !out_valid || !out_stall;

  always_comb begin
    we = 1'b0;
    waddr = w[9:0];
    wdata = rdata | (64'd1 << b);
    re = 1'b0;
    raddr = w[9:0];
    if (cmd.clr_wr) begin
      we = 1'b1;
      waddr = clr;
      wdata = '0;
    end else if (cmd.alloc_wr) begin
      we = 1'b1;
    end else if (cmd.rel_wr) begin
      we = 1'b1;
      waddr = rid[15:6];
      wdata = rdata & ~(64'd1 << rid[5:0]);
    end
    if (cmd.rd_word) begin
      re = 1'b1;
    end else if (cmd.frd) begin
      re = 1'b1;
      raddr = {t[7:0], fk};
    end else if (cmd.rel_rd) begin
      re = 1'b1;
      raddr = rid[15:6];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
      top <= '0;
      cap <= 17'd65536;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr <= clr + 10'd1;
      end
      if (cfg_fire) begin
        cap <= capacity;
      end
      if (cmd.facc && st.fk_last && ((acc & rdata) == {WordBits{1'b1}})) begin
        top[t[7:0]] <= 1'b1;
      end
      if (cmd.rel_wr) begin
        top[rid[15:8]] <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode;
      rid <= row_id;
    end
    if (cmd.init_t) begin
      t <= {1'b0, rid[15:8]};
      lo <= rid;
    end
    if (cmd.next_t) begin
      t <= t + 9'd1;
      lo <= {t[7:0] + 8'd1, 8'h00};
    end
    if (cmd.set_w) begin
      w <= {1'b0, lo[15:6]};
    end
    if (cmd.next_w) begin
      w <= w_inc;
    end
    if (cmd.alloc_wr) begin
      fk <= 2'd0;
      acc <= {WordBits{1'b1}};
      res_st <= ST_OK;
      res_id <= {w[9:0], b};
    end
    if (cmd.facc) begin
      acc <= acc & rdata;
      fk <= fk + 2'd1;
    end
    if (cmd.rel_wr) begin
      res_st <= ST_OK;
      res_id <= rid;
    end
    if (cmd.fail_alloc) begin
      res_st <= ST_NO_FREE;
      res_id <= '0;
    end
    if (cmd.fail_rel) begin
      res_st <= ST_BAD_REL;
      res_id <= '0;
    end
    if (cmd.out_load) begin
      status <= res_st;
      result_id <= res_id;
    end
  end

endmodule

@@ rtl/core/hierarchical_bitmap_id_allocator.sv @@
// Allocates and frees 16-bit ids kept in a two-level bitmap: one leaf bit per id in a
// 1024 x 64 memory and one subtree-full bit per 256 ids. One item is handled at a time
// and in_stall stays high until its result beat has been loaded into the output register.
// A release reads the leaf word of the id and clears its bit if set, else fails; an id out
// of range fails at once. An allocate starts at the hint's subtree, skips full subtrees,
// reads each leaf word in range and takes the lowest free id at or above the hint, then
// reads the four leaf words of that subtree to update its subtree-full bit; a hint out of
// range fails at once. A result beat held by out_stall keeps the block busy. After reset
// the leaf memory is cleared word by word, during which no item is accepted. Capacity
// may be written at any time the block is idle, and is clamped to 256 when LEVELS is 1.
module hierarchical_bitmap_id_allocator #(
  parameter int unsigned LEVELS = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [15:0] row_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] result_id,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] capacity
);
  import hbid_pkg::*;

  cmd_t  cmd;
  stat_t st;
  logic  idle;

  assign in_stall  = !idle;
  assign cfg_ready = 1'b1;

  hbid_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_valid && idle),
    .st      (st),
    .cmd     (cmd),
    .idle    (idle)
  );

  hbid_dp #(.LEVELS(LEVELS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .mode      (mode),
    .row_id    (row_id),
    .cfg_fire  (cfg_valid && cfg_ready),
    .capacity  (capacity),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .result_id (result_id)
  );

endmodule

@@ rtl/core/hbid_checker.sv @@
module hbid_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [15:0] result_id
);
  import hbid_pkg::*;

  // A stalled result beat holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(result_id))
    else $error("stalled result beat changed");

  // A failed item reports id zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> result_id == 16'd0)
    else $error("failure beat with nonzero id");

  // Status never carries the unused code.
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_OK || status == ST_NO_FREE || status == ST_BAD_REL)
    else $error("invalid status code");

  // Only one item is in flight, so input is stalled right after an accept.
  a_one: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while busy");

endmodule

bind hierarchical_bitmap_id_allocator hbid_checker u_hbid_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .result_id (result_id)
);

@@ tb/testbench.sv @@
module testbench;
  import hbid_pkg::*;

  localparam bit MODE_ALLOC = 1'b0;
  localparam bit MODE_RELEASE = 1'b1;
  localparam int IdSpace = 65536;
  localparam int CycleLimit = 4000000;

  typedef struct {
    status_code_t status;
    logic [15:0] id;
  } id_grant_t;

  class id_pool_board;
    bit used[IdSpace];
    bit subtree_full[256];
    int unsigned capacity_reg;
    int unsigned live_ids[$];
    id_grant_t pending[$];
    int errors;

    function new();
      capacity_reg = IdSpace;
      errors = 0;
    endfunction

    function int unsigned usable();
      return (capacity_reg > IdSpace) ? IdSpace : capacity_reg;
    endfunction

    function void refresh_full(int unsigned t);
      bit all_set;
      all_set = 1;
      for (int i = 0; i < 256; i++) begin
        if (!used[t * 256 + i]) all_set = 0;
      end
      if (all_set) subtree_full[t] = 1;
    endfunction

    function id_grant_t grant(int unsigned hint);
      id_grant_t g;
      int unsigned cap;
      int unsigned lo;
      int unsigned hi;
      cap = usable();
      g.status = ST_NO_FREE;
      g.id = '0;
      if (hint >= cap) return g;
      for (int unsigned t = hint >> 8; t * 256 < cap; t++) begin
        if (subtree_full[t]) continue;
        lo = (t == (hint >> 8)) ? hint : t * 256;
        hi = (t * 256 + 256 < cap) ? t * 256 + 256 : cap;
        for (int unsigned k = lo; k < hi; k++) begin
          if (!used[k]) begin
            used[k] = 1;
            refresh_full(t);
            live_ids.push_back(k);
            g.status = ST_OK;
            g.id = k[15:0];
            return g;
          end
        end
      end
      return g;
    endfunction

    function id_grant_t give_back(int unsigned rid);
      id_grant_t g;
      g.status = ST_BAD_REL;
      g.id = '0;
      if (rid >= usable() || !used[rid]) return g;
      used[rid] = 0;
      subtree_full[rid >> 8] = 0;
      foreach (live_ids[i]) begin
        if (live_ids[i] == rid) begin
          live_ids.delete(i);
          break;
        end
      end
      g.status = ST_OK;
      g.id = rid[15:0];
      return g;
    endfunction

    function void note_item(bit m, logic [15:0] rid);
      if (m == MODE_ALLOC) pending.push_back(grant(rid));
      else pending.push_back(give_back(rid));
    endfunction

    task report(string what);
      $display("error: %s", what);
      errors++;
    endtask

    task check_result(logic [1:0] st, logic [15:0] rid);
      id_grant_t g;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat status=%0d id=%0d", st, rid));
        return;
      end
      g = pending.pop_front();
      if (st !== g.status)
        report($sformatf("status %0d, expected %0d", st, g.status));
      if (rid !== g.id)
        report($sformatf("result_id %0d, expected %0d", rid, g.id));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic mode = 0;
  logic [15:0] row_id = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] status;
  logic [15:0] result_id;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [16:0] capacity = 17'd65536;

  id_pool_board board = new();
  bit quiet = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int cycles = 0;

  hierarchical_bitmap_id_allocator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .row_id(row_id),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .result_id(result_id),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .capacity(capacity)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("hierarchical_bitmap_id_allocator: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(status, result_id);
    if (hold_req) begin
      hold_req = 0;
      hold_left <= 400;
      out_stall <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 22);
    end
  end

  task send_item(bit m, int unsigned rid);
    if (!quiet && $urandom_range(99) < 22) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1;
    mode <= m;
    row_id <= rid[15:0];
    do @(posedge clk); while (in_stall);
    board.note_item(m, rid[15:0]);
  endtask

  task drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task set_capacity(int unsigned v);
    drain();
    cfg_valid <= 1;
    capacity <= v[16:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    board.capacity_reg = v;
  endtask

  task random_items(int n);
    int unsigned cap;
    int unsigned r;
    int unsigned span;
    cap = board.usable();
    span = (cap > 1024) ? 1024 : cap;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45)
        send_item(MODE_ALLOC, $urandom_range(span - 1));
      else if (r < 55)
        send_item(MODE_ALLOC, $urandom_range(65535));
      else if (r < 90 && board.live_ids.size() != 0)
        send_item(MODE_RELEASE,
                  board.live_ids[$urandom_range(board.live_ids.size() - 1)]);
      else
        send_item(MODE_RELEASE, $urandom_range(65535));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;

    send_item(MODE_ALLOC, 0);
    send_item(MODE_ALLOC, 65535);
    send_item(MODE_ALLOC, 65535);
    send_item(MODE_RELEASE, 65535);
    send_item(MODE_RELEASE, 65535);
    send_item(MODE_RELEASE, 12345);
    send_item(MODE_ALLOC, 63);
    send_item(MODE_ALLOC, 64);
    send_item(MODE_ALLOC, 255);
    send_item(MODE_ALLOC, 256);
    send_item(MODE_ALLOC, 65535);
    send_item(MODE_RELEASE, 0);
    set_capacity(1);
    send_item(MODE_ALLOC, 0);
    send_item(MODE_ALLOC, 0);
    send_item(MODE_ALLOC, 5);
    send_item(MODE_RELEASE, 1);
    send_item(MODE_RELEASE, 65535);
    send_item(MODE_RELEASE, 0);

    set_capacity(512);
    for (int i = 0; i < 300; i++) send_item(MODE_ALLOC, 0);
    hold_req = 1;
    random_items(150);
    set_capacity(300);
    random_items(250);
    set_capacity(65536);
    quiet = 1;
    random_items(250);
    quiet = 0;
    random_items(200);
    set_capacity(257);
    random_items(250);
    set_capacity(1);
    random_items(40);
    set_capacity(65535);
    random_items(250);

    drain();
    if (board.errors == 0)
      $display("hierarchical_bitmap_id_allocator: match");
    else
      $display("hierarchical_bitmap_id_allocator: mismatch");
    $finish;
  end
endmodule
